>>> src/xmoa_pkg.sv
// ----------------------------------------------------------------------------
// xmoa_pkg: shared types and constants for the modrm operand access unit
// item and result beats, controller commands and datapath status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xmoa_pkg;

	localparam int NUM_REGS   = 16;
	localparam int REG_IDX_W  = 4;
	localparam int DATA_W     = 64;
	localparam int LANES      = 8;
	localparam int LANE_IDX_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int RAB_W      = 5;

	// operation codes
	localparam logic [1:0] OP_READ   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_CACHED = 2'd2;

	// access size codes
	localparam logic [1:0] SIZE_BYTE  = 2'd0;
	localparam logic [1:0] SIZE_WORD  = 2'd1;
	localparam logic [1:0] SIZE_DWORD = 2'd2;
	localparam logic [1:0] SIZE_QWORD = 2'd3;

	// base and index selector codes
	localparam logic [4:0] SEL_NONE = 5'd16;
	localparam logic [4:0] SEL_RIP  = 5'd17;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_ADDR_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT   = 2'd1;

	localparam logic [RAB_W-1:0] RAM_ADDR_BITS_RST = 5'd16;

	typedef struct packed {
		logic [1:0]         operation;
		logic [1:0]         access_size;
		logic               rex_present;
		logic [4:0]         base_select;
		logic [4:0]         index_select;
		logic [1:0]         scale_shift;
		logic signed [31:0] displacement;
		logic [63:0]        instr_address;
		logic [3:0]         instr_length;
		logic [63:0]        write_value;
	} xmoa_item_t;

	typedef struct packed {
		logic [63:0] read_value;
		logic [63:0] effective_address;
		logic        fault;
	} xmoa_result_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} xmoa_cfg_wr_t;

	// kind of work an item needs
	typedef enum logic [1:0] {
		KIND_NOP,
		KIND_REG,
		KIND_MEM,
		KIND_CACHED
	} xmoa_kind_t;

	typedef struct packed {
		logic load;
		logic reg_step;
		logic addr_sum;
		logic addr_disp;
		logic range_chk;
		logic mem_issue;
		logic finish;
	} xmoa_cmd_t;

	typedef struct packed {
		xmoa_kind_t kind;
	} xmoa_status_t;

endpackage

>>> src/xmoa_ctrl.sv
// ----------------------------------------------------------------------------
// xmoa_ctrl: sequencer for the modrm operand access unit
// steps each item through decode and, for memory operands, address, range check and ram access
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xmoa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	output xmoa_pkg::xmoa_cmd_t    cmd,
	input  xmoa_pkg::xmoa_status_t status
);
	import xmoa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DISP,
		ST_CHECK,
		ST_ACCESS,
		ST_COLLECT,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = done_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (status.kind)
					KIND_NOP, KIND_REG:     state_d = ST_DONE;
					KIND_MEM, KIND_CACHED:  state_d = ST_DISP;
				endcase
			end
			ST_DISP:    state_d = ST_CHECK;
			ST_CHECK:   state_d = ST_ACCESS;
			ST_ACCESS:  state_d = ST_COLLECT;
			ST_COLLECT: state_d = ST_DONE;
			ST_DONE: begin
				state_d = accept ? ST_DECODE : ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.reg_step  = (state_q == ST_DECODE) &&
		                (status.kind == KIND_NOP || status.kind == KIND_REG);
		cmd.addr_sum  = (state_q == ST_DECODE) &&
		                (status.kind == KIND_MEM || status.kind == KIND_CACHED);
		cmd.addr_disp = (state_q == ST_DISP);
		cmd.range_chk = (state_q == ST_CHECK);
		cmd.mem_issue = (state_q == ST_ACCESS);
		cmd.finish    = (state_q == ST_COLLECT);
	end

	// state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE) && (state_d != ST_DONE);
			done_q  <= (state_d == ST_DONE);
		end
	end

endmodule

>>> src/xmoa_dpath.sv
// ----------------------------------------------------------------------------
// xmoa_dpath: datapath of the modrm operand access unit
// register file, address adders, range check and eight byte-lane ram banks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xmoa_dpath #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  xmoa_pkg::xmoa_item_t   item,
	input  xmoa_pkg::xmoa_cmd_t    cmd,
	input  xmoa_pkg::xmoa_cfg_wr_t cfg_wr,
	output xmoa_pkg::xmoa_status_t status,
	output xmoa_pkg::xmoa_result_t result
);
	import xmoa_pkg::*;

	localparam int ROW_W = MEM_ADDR_BITS - LANE_IDX_W;
	localparam int ROWS  = 2 ** ROW_W;

	// register number of a register operand
	function automatic logic [REG_IDX_W-1:0] reg_num(input xmoa_item_t it);
		logic legacy_byte;
		legacy_byte = (it.access_size == SIZE_BYTE) && !it.rex_present;
		reg_num = legacy_byte ? {2'b00, it.index_select[1:0]} : it.index_select[3:0];
	endfunction

	// ah..bh selection of a register operand
	function automatic logic reg_high(input xmoa_item_t it);
		reg_high = (it.access_size == SIZE_BYTE) && !it.rex_present && it.index_select[2];
	endfunction

	xmoa_item_t             item_q;
	logic [RAB_W-1:0]       ram_addr_bits_q;
	logic                   ram_present_q;
	logic [DATA_W-1:0]      rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0]    rf_valid_q;
	logic [DATA_W-1:0]      rd_a_q;
	logic [DATA_W-1:0]      rd_b_q;
	logic [REG_IDX_W-1:0]   rd_a_addr;
	logic                   rf_we;
	logic [REG_IDX_W-1:0]   rf_waddr;
	logic [DATA_W-1:0]      rf_wdata;
	logic [DATA_W-1:0]      reg_rd_value;
	logic [DATA_W-1:0]      size_mask;
	logic [3:0]             nbytes;
	logic [DATA_W-1:0]      sum_q;
	logic [DATA_W-1:0]      ea_q;
	logic                   fault_q;
	logic [DATA_W-1:0]      last_addr_q;
	logic [DATA_W:0]        span_end;
	logic [RAB_W-1:0]       bits_eff;
	logic                   oob;
	logic [7:0]             lane_rd_q [LANES];
	logic [DATA_W-1:0]      mem_value;
	xmoa_result_t           result_q;

	assign nbytes = 4'd1 << item_q.access_size;
	assign result = result_q;

	// kind of work for the captured item
	always_comb begin
		if (item_q.operation == OP_READ || item_q.operation == OP_WRITE) begin
			status.kind = (item_q.base_select == SEL_NONE) ? KIND_REG : KIND_MEM;
		end else if (item_q.operation == OP_CACHED) begin
			status.kind = KIND_CACHED;
		end else begin
			status.kind = KIND_NOP;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_addr_bits_q <= RAM_ADDR_BITS_RST;
			ram_present_q   <= 1'b1;
		end else if (cfg_wr.we) begin
			unique case (cfg_wr.index)
				CFG_RAM_ADDR_BITS: ram_addr_bits_q <= cfg_wr.data[RAB_W-1:0];
				CFG_RAM_PRESENT:   ram_present_q   <= cfg_wr.data[0];
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
	end

	// register file read ports, captured with the item
	assign rd_a_addr = (item.base_select == SEL_NONE) ? reg_num(item) : item.base_select[3:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_a_q <= rf_valid_q[rd_a_addr] ? rf_mem[rd_a_addr] : '0;
			rd_b_q <= rf_valid_q[item.index_select[3:0]] ? rf_mem[item.index_select[3:0]] : '0;
		end
		if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
		end else if (rf_we) begin
			rf_valid_q[rf_waddr] <= 1'b1;
		end
	end

	// register operand read and merge
	always_comb begin
		unique case (item_q.access_size)
			SIZE_BYTE:  size_mask = 64'h0000_0000_0000_00ff;
			SIZE_WORD:  size_mask = 64'h0000_0000_0000_ffff;
			SIZE_DWORD: size_mask = 64'h0000_0000_ffff_ffff;
			SIZE_QWORD: size_mask = '1;
		endcase
		reg_rd_value = (reg_high(item_q) ? (rd_a_q >> 8) : rd_a_q) & size_mask;
		rf_waddr = reg_num(item_q);
		rf_we    = cmd.reg_step && (status.kind == KIND_REG) &&
		           (item_q.operation == OP_WRITE);
		unique case (item_q.access_size)
			SIZE_BYTE: begin
				if (reg_high(item_q)) begin
					rf_wdata = {rd_a_q[63:16], item_q.write_value[7:0], rd_a_q[7:0]};
				end else begin
					rf_wdata = {rd_a_q[63:8], item_q.write_value[7:0]};
				end
			end
			SIZE_WORD:  rf_wdata = {rd_a_q[63:16], item_q.write_value[15:0]};
			SIZE_DWORD: rf_wdata = {32'd0, item_q.write_value[31:0]};
			SIZE_QWORD: rf_wdata = item_q.write_value;
		endcase
	end

	// address: base part, then displacement
	always_ff @(posedge clk) begin
		if (cmd.addr_sum) begin
			if (status.kind == KIND_CACHED) begin
				sum_q <= last_addr_q;
			end else if (item_q.base_select == SEL_RIP) begin
				sum_q <= item_q.instr_address + DATA_W'(item_q.instr_length);
			end else if (item_q.index_select == SEL_NONE) begin
				sum_q <= rd_a_q;
			end else begin
				sum_q <= rd_a_q + (rd_b_q << item_q.scale_shift);
			end
		end
		if (cmd.addr_disp) begin
			if (status.kind == KIND_CACHED) begin
				ea_q <= sum_q;
			end else begin
				ea_q <= sum_q + DATA_W'(item_q.displacement);
			end
		end
	end

	// range check on the last byte of the access
	always_comb begin
		span_end = {1'b0, ea_q} + (DATA_W + 1)'(nbytes - 4'd1);
		bits_eff = (ram_addr_bits_q > RAB_W'(MEM_ADDR_BITS)) ? RAB_W'(MEM_ADDR_BITS)
		                                                      : ram_addr_bits_q;
		oob = (span_end[DATA_W-1:MEM_ADDR_BITS] != '0);
		for (int i = 0; i < MEM_ADDR_BITS; i++) begin
			if (span_end[i] && (RAB_W'(i) >= bits_eff)) oob = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.range_chk) fault_q <= !ram_present_q || span_end[DATA_W] || oob;
	end

	// last read address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_addr_q <= '0;
		end else if (cmd.mem_issue && !fault_q && item_q.operation == OP_READ) begin
			last_addr_q <= ea_q;
		end
	end

	// byte-lane ram banks, one per low address bit pattern
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [7:0]            bank [ROWS];
		logic [LANE_IDX_W-1:0] ofs;
		logic [ROW_W-1:0]      row;
		logic                  en;
		logic [DATA_W-1:0]     wshift;

		always_comb begin
			ofs    = LANE_IDX_W'(l) - ea_q[LANE_IDX_W-1:0];
			row    = ea_q[MEM_ADDR_BITS-1:LANE_IDX_W] +
			         ROW_W'(LANE_IDX_W'(l) < ea_q[LANE_IDX_W-1:0]);
			en     = {1'b0, ofs} < nbytes;
			wshift = item_q.write_value >> {ofs, 3'b000};
		end

		always_ff @(posedge clk) begin
			if (cmd.mem_issue) begin
				lane_rd_q[l] <= bank[row];
				if (!fault_q && en && item_q.operation != OP_READ) bank[row] <= wshift[7:0];
			end
		end
	end

	// gather lanes back into operand byte order
	always_comb begin
		mem_value = '0;
		for (int k = 0; k < LANES; k++) begin
			if (4'(k) < nbytes) begin
				mem_value[k*8 +: 8] = lane_rd_q[ea_q[LANE_IDX_W-1:0] + LANE_IDX_W'(k)];
			end
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (cmd.reg_step) begin
			result_q.read_value        <= (status.kind == KIND_REG &&
			                               item_q.operation == OP_READ) ? reg_rd_value : '0;
			result_q.effective_address <= '0;
			result_q.fault             <= 1'b0;
		end else if (cmd.finish) begin
			result_q.read_value        <= (!fault_q && item_q.operation == OP_READ)
			                              ? mem_value : '0;
			result_q.effective_address <= ea_q;
			result_q.fault             <= fault_q;
		end
	end

endmodule

>>> src/x86_modrm_operand_access.sv
// ----------------------------------------------------------------------------
// x86_modrm_operand_access: register or memory operand read and write unit
// sequence from start to result strobe: register operands and no-ops pass
// decode then done; memory operands also pass address adds, check, bank access
// next start is taken in the cycle the result shows; reset clears registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module x86_modrm_operand_access #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  xmoa_pkg::xmoa_item_t                    item,
	output logic                                   done,
	output xmoa_pkg::xmoa_result_t                  result,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [xmoa_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [xmoa_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import xmoa_pkg::*;

	xmoa_cmd_t    cmd;
	xmoa_status_t status;
	xmoa_cfg_wr_t cfg_wr;

	// configuration beats are always taken
	assign cfg_ready    = 1'b1;
	assign cfg_wr.we    = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	xmoa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	xmoa_dpath #(
		.MEM_ADDR_BITS (MEM_ADDR_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.cfg_wr (cfg_wr),
		.status (status),
		.result (result)
	);

endmodule

>>> sim/tb_x86_modrm_operand_access.sv
// ----------------------------------------------------------------------------
// tb_x86_modrm_operand_access: self-checking bench for the r/m operand unit
// drives register and memory operand accesses plus config writes, predicts
// every result beat from a local register file and ram image, and checks
// each strobed result in order against the predicted one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_x86_modrm_operand_access;

	import xmoa_pkg::*;

	localparam int MEM_BITS = 16;
	localparam logic [1:0] OP_NOP = 2'd3;

	// operand state tracker: predicts each access and holds results still due
	class operand_tracker;
		logic [63:0] regs [NUM_REGS];
		logic [7:0] ram [0:(1 << MEM_BITS) - 1];
		bit written [0:(1 << MEM_BITS) - 1];
		logic [63:0] last_addr;
		logic [4:0] ram_bits;
		logic ram_on;
		xmoa_result_t outcomes_due [$];
		int errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			last_addr = '0;
			ram_bits = RAM_ADDR_BITS_RST;
			ram_on = 1'b1;
			errors = 0;
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %h want %h", what, got, want);
			errors++;
		endtask

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_RAM_ADDR_BITS: ram_bits = data[4:0];
				CFG_RAM_PRESENT: ram_on = data[0];
				default: ;
			endcase
		endfunction

		function int span_bits();
			return (ram_bits > MEM_BITS) ? MEM_BITS : int'(ram_bits);
		endfunction

		// memory operand address, modulo 2^64
		function logic [63:0] addr_of(xmoa_item_t it);
			logic [63:0] disp;
			logic [63:0] scaled;
			disp = {{32{it.displacement[31]}}, it.displacement};
			if (it.base_select == SEL_RIP)
				return it.instr_address + 64'(it.instr_length) + disp;
			scaled = (it.index_select == SEL_NONE) ? '0 :
				regs[it.index_select[3:0]] << it.scale_shift;
			return regs[it.base_select[3:0]] + scaled + disp;
		endfunction

		function bit in_ram(logic [63:0] addr, int nbytes);
			logic [63:0] last;
			if (!ram_on)
				return 0;
			last = addr + 64'(nbytes - 1);
			if (last < addr)
				return 0;
			return (last >> span_bits()) == 0;
		endfunction

		function bit all_written(logic [63:0] addr, int nbytes);
			for (int i = 0; i < nbytes; i++)
				if (!written[addr[15:0] + 16'(i)])
					return 0;
			return 1;
		endfunction

		function void store(logic [63:0] addr, int nbytes, logic [63:0] wv);
			for (int i = 0; i < nbytes; i++) begin
				ram[addr[15:0] + 16'(i)] = wv[8*i +: 8];
				written[addr[15:0] + 16'(i)] = 1'b1;
			end
		endfunction

		// apply one accepted access and queue the result it must give
		function void accept_access(xmoa_item_t it);
			int nbytes;
			logic [63:0] mask;
			logic [63:0] wv;
			logic [3:0] r;
			bit high;
			xmoa_result_t due;
			nbytes = 1 << it.access_size;
			mask = (it.access_size == SIZE_QWORD) ? '1 : (64'd1 << (8 * nbytes)) - 64'd1;
			wv = it.write_value;
			due = '0;
			if (it.operation == OP_NOP) begin
				// no action, all zero
			end else if (it.operation == OP_CACHED) begin
				due.effective_address = last_addr;
				if (in_ram(last_addr, nbytes))
					store(last_addr, nbytes, wv);
				else
					due.fault = 1'b1;
			end else if (it.base_select == SEL_NONE) begin
				// register operand, legacy byte regs pick ah..bh on index bit 2
				r = it.index_select[3:0];
				high = 1'b0;
				if (it.access_size == SIZE_BYTE && !it.rex_present) begin
					high = it.index_select[2];
					r = {2'b00, it.index_select[1:0]};
				end
				if (it.operation == OP_READ) begin
					due.read_value = (high ? regs[r] >> 8 : regs[r]) & mask;
				end else begin
					case (it.access_size)
						SIZE_BYTE: begin
							if (high)
								regs[r][15:8] = wv[7:0];
							else
								regs[r][7:0] = wv[7:0];
						end
						SIZE_WORD: regs[r][15:0] = wv[15:0];
						default: regs[r] = wv & mask;
					endcase
				end
			end else begin
				// memory operand, faulting accesses leave state alone
				due.effective_address = addr_of(it);
				if (!in_ram(due.effective_address, nbytes)) begin
					due.fault = 1'b1;
				end else if (it.operation == OP_READ) begin
					for (int i = 0; i < nbytes; i++)
						due.read_value[8*i +: 8] = ram[due.effective_address[15:0] + 16'(i)];
					last_addr = due.effective_address;
				end else begin
					store(due.effective_address, nbytes, wv);
				end
			end
			outcomes_due.push_back(due);
		endfunction

		task check_outcome(xmoa_result_t got);
			xmoa_result_t due;
			if (outcomes_due.size() == 0) begin
				report("result with none pending", got.effective_address, '0);
				return;
			end
			due = outcomes_due.pop_front();
			if (got.read_value !== due.read_value)
				report("read_value", got.read_value, due.read_value);
			if (got.effective_address !== due.effective_address)
				report("effective_address", got.effective_address, due.effective_address);
			if (got.fault !== due.fault)
				report("fault", 64'(got.fault), 64'(due.fault));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	xmoa_item_t item;
	logic done;
	xmoa_result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	operand_tracker tracker;
	int calm_left = 0;

	x86_modrm_operand_access #(
		.MEM_ADDR_BITS(MEM_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result beats, sampled before the edge updates them
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_outcome(result);
	end

	// hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic xmoa_item_t mk(logic [1:0] op, logic [1:0] size, logic rex,
			logic [4:0] base, logic [4:0] idx, logic [1:0] scale, logic [31:0] disp,
			logic [63:0] ip, logic [3:0] len, logic [63:0] wv);
		xmoa_item_t it;
		it.operation = op;
		it.access_size = size;
		it.rex_present = rex;
		it.base_select = base;
		it.index_select = idx;
		it.scale_shift = scale;
		it.displacement = disp;
		it.instr_address = ip;
		it.instr_length = len;
		it.write_value = wv;
		return it;
	endfunction

	// set displacement (or rip) so the access lands on target
	function automatic void aim(inout xmoa_item_t it, input logic [63:0] target);
		logic [31:0] saved;
		logic [63:0] need;
		if (it.base_select != SEL_RIP) begin
			saved = it.displacement;
			it.displacement = '0;
			need = target - tracker.addr_of(it);
			if (need[63:31] == '0 || need[63:31] == '1) begin
				it.displacement = need[31:0];
				return;
			end
			it.displacement = saved;
			it.base_select = SEL_RIP;
		end
		it.instr_address = target - 64'(it.instr_length)
			- {{32{it.displacement[31]}}, it.displacement};
	endfunction

	// hold one beat on the item port until it is taken
	task automatic drive_access(xmoa_item_t it);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		tracker.accept_access(it);
	endtask

	// mostly short gaps, a few long ones, and stretches with none
	task automatic idle_gap();
		int n;
		int r;
		n = 0;
		if (calm_left > 0) begin
			calm_left--;
		end else if ($urandom_range(0, 99) < 4) begin
			calm_left = $urandom_range(20, 60);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50)
				n = 0;
			else if (r < 82)
				n = $urandom_range(1, 3);
			else if (r < 96)
				n = $urandom_range(4, 10);
			else
				n = $urandom_range(20, 40);
		end
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop issuing, let all results land, then allow the pipe to drain
	// the last beat keeps the unit busy for the next edge, so start drops there
	task automatic settle();
		@(posedge clk);
		start <= 1'b0;
		for (int k = 0; k < 200 && tracker.outcomes_due.size() != 0; k++)
			@(posedge clk);
		if (tracker.outcomes_due.size() != 0) begin
			tracker.report("results never seen", 64'(tracker.outcomes_due.size()), '0);
			tracker.outcomes_due.delete();
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic run_random(int count);
		xmoa_item_t it;
		int kind;
		int pick;
		int nbytes;
		logic [63:0] target;
		for (int n = 0; n < count; n++) begin
			it.operation = OP_READ;
			it.access_size = 2'($urandom);
			it.rex_present = 1'($urandom);
			it.base_select = 5'($urandom_range(0, 15));
			it.index_select = 5'($urandom_range(0, 16));
			it.scale_shift = 2'($urandom);
			it.displacement = $urandom;
			it.instr_address = {$urandom, $urandom};
			it.instr_length = 4'($urandom);
			it.write_value = {$urandom, $urandom};
			nbytes = 1 << it.access_size;
			kind = $urandom_range(0, 99);
			if (kind < 28) begin
				// register operand, small values keep later addressing usable
				it.base_select = SEL_NONE;
				it.operation = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
				if ($urandom_range(0, 9) == 0)
					it.index_select = 5'($urandom_range(16, 31));
				if ($urandom_range(0, 9) < 6)
					it.write_value = 64'($urandom_range(0, 4095));
			end else if (kind < 38) begin
				it.operation = OP_CACHED;
			end else if (kind < 41) begin
				it.operation = OP_NOP;
				it.base_select = 5'($urandom);
				it.index_select = 5'($urandom);
			end else begin
				// memory operand, mostly aimed into a small window or at the edge
				it.operation = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
				if ($urandom_range(0, 9) == 0)
					it.base_select = 5'($urandom_range(18, 31));
				if ($urandom_range(0, 9) == 0)
					it.index_select = 5'($urandom_range(17, 31));
				if ($urandom_range(0, 6) == 0)
					it.base_select = SEL_RIP;
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					if (pick < 65)
						target = 64'($urandom_range(0, 255));
					else if (pick < 80)
						target = (64'd1 << tracker.span_bits()) - 64'(nbytes)
							+ 64'($urandom_range(0, nbytes));
					else
						target = -64'($urandom_range(1, 8));
					aim(it, target);
				end
				// never read ram bytes that hold nothing yet
				target = tracker.addr_of(it);
				if (it.operation == OP_READ && tracker.in_ram(target, nbytes)
						&& !tracker.all_written(target, nbytes))
					it.operation = OP_WRITE;
			end
			drive_access(it);
			idle_gap();
		end
	endtask

	initial begin
		xmoa_item_t it;
		tracker = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_cfg(CFG_RAM_ADDR_BITS, 8'd16);
		write_cfg(CFG_RAM_PRESENT, 8'd1);

		// register operands: legacy high bytes, rex low bytes, merges, zero-extend
		drive_access(mk(OP_WRITE, SIZE_QWORD, 1'b0, SEL_NONE, 5'd0, 2'd0, '0, '0, 4'd1, '1));
		drive_access(mk(OP_READ, SIZE_BYTE, 1'b0, SEL_NONE, 5'd4, 2'd0, '0, '0, 4'd1, '0));
		drive_access(mk(OP_WRITE, SIZE_BYTE, 1'b0, SEL_NONE, 5'd5, 2'd0, '0, '0, 4'd1,
			64'h00000000_000000a5));
		drive_access(mk(OP_WRITE, SIZE_BYTE, 1'b1, SEL_NONE, 5'd13, 2'd0, '0, '0, 4'd1,
			64'hffffffff_ffffff5a));
		drive_access(mk(OP_WRITE, SIZE_WORD, 1'b0, SEL_NONE, 5'd2, 2'd0, '0, '0, 4'd1,
			64'h12345678_9abcdef0));
		drive_access(mk(OP_WRITE, SIZE_DWORD, 1'b0, SEL_NONE, 5'd0, 2'd0, '0, '0, 4'd1, '1));
		drive_access(mk(OP_READ, SIZE_QWORD, 1'b1, SEL_NONE, 5'd0, 2'd0, '0, '0, 4'd1, '0));
		drive_access(mk(OP_READ, SIZE_BYTE, 1'b1, SEL_NONE, 5'd5, 2'd0, '0, '0, 4'd1, '0));
		drive_access(mk(OP_READ, SIZE_WORD, 1'b0, SEL_NONE, 5'd20, 2'd0, '0, '0, 4'd1, '0));
		drive_access(mk(OP_READ, SIZE_BYTE, 1'b0, SEL_NONE, 5'd5, 2'd0, '0, '0, 4'd1, '0));

		// memory: store, load, cached store, rip-relative, wrap and edge faults
		drive_access(mk(OP_WRITE, SIZE_QWORD, 1'b0, 5'd3, SEL_NONE, 2'd0, 32'd16, '0, 4'd1,
			64'h01234567_89abcdef));
		drive_access(mk(OP_READ, SIZE_QWORD, 1'b0, 5'd3, SEL_NONE, 2'd0, 32'd16, '0, 4'd1, '0));
		drive_access(mk(OP_CACHED, SIZE_DWORD, 1'b0, 5'd0, 5'd0, 2'd0, '0, '0, 4'd1, '1));
		drive_access(mk(OP_READ, SIZE_BYTE, 1'b0, SEL_RIP, SEL_NONE, 2'd0, 32'd1, '0, 4'd15,
			'0));
		drive_access(mk(OP_WRITE, SIZE_QWORD, 1'b0, 5'd3, SEL_NONE, 2'd0, '1, '0, 4'd1, '1));
		drive_access(mk(OP_WRITE, SIZE_BYTE, 1'b0, 5'd3, SEL_NONE, 2'd0, 32'd65535, '0, 4'd1,
			64'h3c));
		drive_access(mk(OP_READ, SIZE_BYTE, 1'b0, 5'd3, SEL_NONE, 2'd0, 32'd65535, '0, 4'd1,
			'0));
		drive_access(mk(OP_READ, SIZE_WORD, 1'b0, 5'd3, SEL_NONE, 2'd0, 32'd65535, '0, 4'd1,
			'0));
		drive_access(mk(OP_NOP, SIZE_QWORD, 1'b1, 5'd31, 5'd31, 2'd3, '1, '1, 4'd15, '1));

		// scaled index, aliased selectors above the named codes
		drive_access(mk(OP_WRITE, SIZE_QWORD, 1'b0, SEL_NONE, 5'd6, 2'd0, '0, '0, 4'd1,
			64'd8));
		it = mk(OP_WRITE, SIZE_QWORD, 1'b0, 5'd3, 5'd6, 2'd3, 32'h5555_5555, '0, 4'd1,
			64'hfedcba98_76543210);
		aim(it, 64'd64);
		drive_access(it);
		drive_access(mk(OP_READ, SIZE_QWORD, 1'b0, 5'd19, 5'd22, 2'd3, '0, '0, 4'd1, '0));
		drive_access(mk(OP_READ, SIZE_BYTE, 1'b0, SEL_RIP, SEL_NONE, 2'd0, 32'h8000_0000, '1,
			4'd15, '0));
		drive_access(mk(OP_WRITE, SIZE_BYTE, 1'b0, 5'd3, SEL_NONE, 2'd0, 32'h7fff_ffff, '0,
			4'd1, '1));
		drive_access(mk(OP_CACHED, SIZE_QWORD, 1'b0, SEL_NONE, SEL_NONE, 2'd0, '0, '0, 4'd1,
			64'h80000000_00000001));

		run_random(400);

		// shrink, remove, restore and oversize the ram window
		settle();
		write_cfg(CFG_RAM_ADDR_BITS, {3'($urandom), 5'd8});
		run_random(250);

		settle();
		write_cfg(CFG_RAM_PRESENT, {7'($urandom), 1'b0});
		run_random(100);

		settle();
		write_cfg(CFG_RAM_PRESENT, {7'($urandom), 1'b1});
		write_cfg(CFG_RAM_ADDR_BITS, {3'($urandom), 5'd1});
		run_random(100);

		settle();
		write_cfg(CFG_RAM_ADDR_BITS, {3'($urandom), 5'd31});
		run_random(100);

		settle();
		write_cfg(CFG_RAM_ADDR_BITS, {3'($urandom), 5'd16});
		run_random(350);

		settle();
		if (tracker.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
src/xmoa_pkg.sv
src/xmoa_ctrl.sv
src/xmoa_dpath.sv
src/x86_modrm_operand_access.sv
sim/tb_x86_modrm_operand_access.sv
